>>> rtl/lps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear-probe id set.
// No dependencies; imported by every module of the block.
package lps_pkg;

    localparam int DEF_TABLE_SLOTS = 64;
    localparam int DEF_MAX_ENTRIES = 42;
    localparam int ID_W            = 32;
    localparam int COUNT_OUT_W     = 6;
    localparam int OR_GROUP        = 8;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_DONE
    } t_state;

    // Controls broadcast to every cell of the id chain.
    typedef struct packed {
        logic cmp;
        logic shift;
    } t_cell_ctrl;

endpackage

>>> rtl/linear_probe_id_set.sv
`timescale 1ns / 1ps
// Linear-probe id set: a set of nonzero 32-bit ids with a saturating count.
// Uses lps_pkg, lps_cell and lps_or_tree.
//
// Usage:
//   Command side: drive i_operation (query or add) and i_user_id and raise
//   start; the command transfers at a rising edge where start is high and
//   busy is low. busy stays high until the result has been produced.
//   Result side: o_present, o_saturated and o_entry_count are valid for
//   exactly one cycle while o_done is high; the receiver cannot stall, so
//   it must capture the result in that cycle.
//   Sequence: o_done rises after the compare, reduce and update states; busy
//   drops at the same edge, so a new command waits until the last one is done.
//   The four steps are capture, compare in every cell of the chain, the
//   registered OR of the hit flags, and the update of the chain and count.
//   Storage is a chain of TABLE_SLOTS cells; an add that inserts a new id
//   shifts the chain by one cell and enters the id at the head, so the stored
//   ids are always a contiguous run from the head.
//   Reset (synchronous, active low) empties every cell and the count; no
//   clearing pass is needed.
module linear_probe_id_set
    import lps_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   i_operation,
    input  logic [ID_W-1:0]        i_user_id,
    output logic                   busy,
    output logic                   o_done,
    output logic                   o_present,
    output logic                   o_saturated,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state          r_state, n_state;
    logic            r_op;
    logic [ID_W-1:0] r_uid;
    logic [CW-1:0]   r_count, n_count;
    logic            r_done, n_done;
    logic            r_present, n_present;
    logic            r_saturated, n_saturated;

    t_cell_ctrl      w_ctrl;
    logic            w_red_en;
    logic            w_accept;
    logic            w_any;
    logic            w_sat_before;
    logic            w_insert;
    logic            w_member;

    logic [ID_W-1:0]        w_id    [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] w_valid;
    logic [TABLE_SLOTS-1:0] w_hits;
    logic [CW+COUNT_OUT_W-1:0] w_count_ext;

    assign w_accept = start && (r_state == S_IDLE);

    // Cell chain: cell 0 takes the new id, every other cell its neighbor's slot.
    for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
        logic [ID_W-1:0] w_prev_id;
        logic            w_prev_valid;

        if (i == 0) begin : g_head
            assign w_prev_id    = r_uid;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_id    = w_id[i-1];
            assign w_prev_valid = w_valid[i-1];
        end

        lps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_key        (r_uid),
            .i_prev_id    (w_prev_id),
            .i_prev_valid (w_prev_valid),
            .o_id         (w_id[i]),
            .o_valid      (w_valid[i]),
            .o_hit        (w_hits[i])
        );
    end

    lps_or_tree #(
        .N (TABLE_SLOTS)
    ) u_or_tree (
        .i_clk  (i_clk),
        .i_en   (w_red_en),
        .i_hits (w_hits),
        .o_any  (w_any)
    );

    // Decision made in the update step.
    assign w_sat_before = r_count >= CW'(MAX_ENTRIES);
    assign w_insert     = !w_sat_before && (r_uid != '0) && !w_any && (r_op == OP_ADD)
                          && !w_valid[TABLE_SLOTS-1];
    assign w_member     = !w_sat_before && (r_uid != '0) && (w_any || w_insert);

    always_comb begin
        n_state     = r_state;
        w_ctrl      = '0;
        w_red_en    = 1'b0;
        n_count     = r_count;
        n_done      = 1'b0;
        n_present   = r_present;
        n_saturated = r_saturated;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctrl.cmp = 1'b1;
                n_state    = S_RED;
            end
            S_RED: begin
                w_red_en = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                w_ctrl.shift = w_insert;
                n_count      = r_count + CW'(w_insert);
                n_saturated  = n_count >= CW'(MAX_ENTRIES);
                n_present    = w_member || n_saturated;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Command and result payload: hold between transfers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_operation;
            r_uid <= i_user_id;
        end
        r_present   <= n_present;
        r_saturated <= n_saturated;
    end

    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, r_count};

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_present     = r_present;
    assign o_saturated   = r_saturated;
    assign o_entry_count = w_count_ext[COUNT_OUT_W-1:0];

endmodule

>>> rtl/lps_cell.sv
`timescale 1ns / 1ps
// One slot of the id chain: holds an id and its valid bit, compares it
// against the broadcast key, and takes its neighbor's slot on insert. Uses lps_pkg.
module lps_cell
    import lps_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctrl      i_ctrl,
    input  logic [ID_W-1:0] i_key,
    input  logic [ID_W-1:0] i_prev_id,
    input  logic            i_prev_valid,
    output logic [ID_W-1:0] o_id,
    output logic            o_valid,
    output logic            o_hit
);

    logic [ID_W-1:0] r_id;
    logic            r_valid;
    logic            r_hit;
    logic            n_hit;

    assign n_hit = r_valid && (r_id == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_id <= i_prev_id;
        end
        if (i_ctrl.cmp) begin
            r_hit <= n_hit;
        end
    end

    assign o_id    = r_id;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

>>> rtl/lps_or_tree.sv
`timescale 1ns / 1ps
// Registered OR reduction of the per-cell hit flags: one register per group
// of OR_GROUP cells, then a final OR. Uses lps_pkg.
module lps_or_tree
    import lps_pkg::*;
#(
    parameter int N = DEF_TABLE_SLOTS
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [N-1:0] i_hits,
    output logic         o_any
);

    localparam int NG = (N + OR_GROUP - 1) / OR_GROUP;

    logic [NG-1:0] r_grp;

    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int LO = g * OR_GROUP;
        localparam int HI = (LO + OR_GROUP > N) ? N - 1 : LO + OR_GROUP - 1;
        logic n_grp;

        assign n_grp = |i_hits[HI:LO];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_grp[g] <= n_grp;
            end
        end
    end

    assign o_any = |r_grp;

endmodule

>>> rtl/lps_checker.sv
`timescale 1ns / 1ps
// Port-level checks for linear_probe_id_set, attached by the bind below.
// Imports lps_pkg.
module lps_checker
    import lps_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_present,
    input logic o_saturated
);

    // A transferred command must make the block busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command transfer");

    // Every result closes a command that was in progress.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a command in progress");

    // Results are one cycle wide and never back to back.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // A saturated table answers present.
    a_sat_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_saturated |-> o_present)
        else $error("saturated result not present");

    // Reset leaves the block idle with no result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done)
        else $error("block not idle after reset");

endmodule

bind linear_probe_id_set lps_checker u_lps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_present   (o_present),
    .o_saturated (o_saturated)
);
